FILE: sv/clut_pkg.sv
// package for the colour lookup pixel expander
// payload structs, request and mode codes, register indexes and pixel masks
// no dependencies
package clut_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_DISABLE = 1'd1;

    localparam logic [2:0] REQ_PIXEL      = 3'd0;
    localparam logic [2:0] REQ_DAC_ADDR   = 3'd1;
    localparam logic [2:0] REQ_DAC_COLOR  = 3'd2;
    localparam logic [2:0] REQ_FRAME_TICK = 3'd3;
    localparam logic [2:0] REQ_IRQ_ACK    = 3'd4;
    localparam logic [2:0] REQ_STATUS     = 3'd5;

    localparam logic [1:0] MODE_1BPP = 2'd0;
    localparam logic [1:0] MODE_2BPP = 2'd1;
    localparam logic [1:0] MODE_4BPP = 2'd2;
    localparam logic [1:0] MODE_8BPP = 2'd3;

    localparam logic [2:0] MODE_DIRECT     = 3'd4;
    localparam logic [2:0] MODE_DIRECT_ALT = 3'd7;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] data;
    } t_in;

    typedef struct packed {
        logic [31:0] pixel;
        logic        last;
        logic        irq_level;
        logic        status_bit;
        logic        mode_error;
    } t_out;

    function automatic logic [7:0] pix_mask(input logic [1:0] mode);
        logic [7:0] m;
        unique case (mode)
            MODE_1BPP: m = 8'h80;
            MODE_2BPP: m = 8'hc0;
            MODE_4BPP: m = 8'hf0;
            MODE_8BPP: m = 8'hff;
        endcase
        return m;
    endfunction

endpackage

FILE: sv/clut_ramdac_pixel_expander.sv
// path: a transaction is registered in the expansion stage and then in the result stage before its result is offered
// throughput: one result per cycle while the result side does not stall; a palette-mode byte holds the expansion
// stage until its 8, 4, 2 or 1 pixels (8 >> mode) are looked up, one lookup per cycle on the palette read port
// reset: synchronous, sets mode 0 with the interrupt disabled, clears dac state, interrupt, toggle and the
// PALETTE_DEPTH (256 by default) written flags together, so the palette reads as zero with no clearing pass
module clut_ramdac_pixel_expander #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  clut_pkg::t_in                       i_in,
    output logic                                o_valid,
    input  logic                                i_stall,
    output clut_pkg::t_out                      o_out,
    input  logic                                i_cfg_we,
    input  logic [clut_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [clut_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic [2:0]  r_color_mode;
    logic        r_irq_dis;

    logic        r_a_valid;
    logic [2:0]  r_a_req;
    logic [31:0] r_a_data;
    logic [2:0]  r_a_left;

    logic [7:0]  r_dac_addr, n_dac_addr;
    logic [1:0]  r_dac_cnt, n_dac_cnt;
    logic [7:0]  r_dac_p0, n_dac_p0;
    logic [7:0]  r_dac_p1, n_dac_p1;
    logic        r_toggle, n_toggle;
    logic        r_irq, n_irq;

    logic        r_b_valid;
    logic        r_b_lookup, n_b_lookup;
    logic [31:0] r_b_pixel, n_b_pixel;
    logic        r_b_last;
    logic        r_b_irq;
    logic        r_b_status, n_b_status;
    logic        r_b_err, n_b_err;

    logic        b_ready;
    logic        a_fire;
    logic        a_pal;
    logic        a_last;
    logic        in_fire;
    logic [7:0]  a_idx;
    logic [7:0]  dac_byte;
    logic        wr_en;
    logic        rd_en;
    logic [31:0] pal_argb;

    assign b_ready  = !r_b_valid || !i_stall;
    assign a_fire   = r_a_valid && b_ready;
    assign a_pal    = (r_a_req == clut_pkg::REQ_PIXEL) && !r_color_mode[2];
    assign a_last   = !a_pal || (r_a_left == 3'd0);
    assign o_stall  = r_a_valid && !(a_fire && a_last);
    assign in_fire  = i_valid && !o_stall;
    assign a_idx    = r_a_data[7:0] & clut_pkg::pix_mask(r_color_mode[1:0]);
    assign dac_byte = r_a_data[31:24];
    assign rd_en    = a_fire && a_pal;
    assign wr_en    = a_fire && (r_a_req == clut_pkg::REQ_DAC_COLOR) && r_dac_cnt[1];

    clut_palette #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_palette (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (wr_en),
        .i_wr_addr(AW'(r_dac_addr)),
        .i_wr_rgb ({r_dac_p0, r_dac_p1, dac_byte}),
        .i_rd_en  (rd_en),
        .i_rd_addr(AW'(a_idx)),
        .o_argb   (pal_argb)
    );

    always_comb begin
        n_dac_addr = r_dac_addr;
        n_dac_cnt  = r_dac_cnt;
        n_dac_p0   = r_dac_p0;
        n_dac_p1   = r_dac_p1;
        n_toggle   = r_toggle;
        n_irq      = r_irq;
        n_b_lookup = 1'b0;
        n_b_pixel  = 32'd0;
        n_b_status = 1'b0;
        n_b_err    = 1'b0;
        case (r_a_req)
            clut_pkg::REQ_PIXEL: begin
                if (a_pal) begin
                    n_b_lookup = 1'b1;
                end else if (r_color_mode == clut_pkg::MODE_DIRECT ||
                             r_color_mode == clut_pkg::MODE_DIRECT_ALT) begin
                    n_b_pixel = r_a_data;
                end else begin
                    n_b_err = 1'b1;
                end
            end
            clut_pkg::REQ_DAC_ADDR: begin
                n_dac_addr = dac_byte;
                n_dac_cnt  = 2'd0;
            end
            clut_pkg::REQ_DAC_COLOR: begin
                if (r_dac_cnt[1]) begin
                    n_dac_addr = r_dac_addr + 8'd1;
                    n_dac_cnt  = 2'd0;
                end else begin
                    if (r_dac_cnt[0]) begin
                        n_dac_p1 = dac_byte;
                    end else begin
                        n_dac_p0 = dac_byte;
                    end
                    n_dac_cnt = r_dac_cnt + 2'd1;
                end
            end
            clut_pkg::REQ_FRAME_TICK: begin
                if (!r_irq_dis) begin
                    n_irq = 1'b1;
                end
            end
            clut_pkg::REQ_IRQ_ACK: begin
                n_irq = 1'b0;
            end
            clut_pkg::REQ_STATUS: begin
                n_toggle   = !r_toggle;
                n_b_status = !r_toggle;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= 3'd0;
            r_irq_dis    <= 1'b1;
            r_a_valid    <= 1'b0;
            r_a_left     <= 3'd0;
            r_dac_addr   <= 8'd0;
            r_dac_cnt    <= 2'd0;
            r_dac_p0     <= 8'd0;
            r_dac_p1     <= 8'd0;
            r_toggle     <= 1'b0;
            r_irq        <= 1'b0;
            r_b_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    clut_pkg::CFG_COLOR_MODE:  r_color_mode <= i_cfg_wdata;
                    clut_pkg::CFG_IRQ_DISABLE: r_irq_dis    <= i_cfg_wdata[0];
                endcase
            end

            if (in_fire) begin
                r_a_valid <= 1'b1;
                r_a_req   <= i_in.req_type;
                r_a_data  <= i_in.data;
                r_a_left  <= (i_in.req_type == clut_pkg::REQ_PIXEL && !r_color_mode[2]) ?
                             (3'd7 >> r_color_mode[1:0]) : 3'd0;
            end else if (a_fire) begin
                if (a_last) begin
                    r_a_valid <= 1'b0;
                end else begin
                    r_a_data[7:0] <= r_a_data[7:0] << (4'd1 << r_color_mode[1:0]);
                    r_a_left      <= r_a_left - 3'd1;
                end
            end

            if (a_fire) begin
                r_dac_addr <= n_dac_addr;
                r_dac_cnt  <= n_dac_cnt;
                r_dac_p0   <= n_dac_p0;
                r_dac_p1   <= n_dac_p1;
                r_toggle   <= n_toggle;
                r_irq      <= n_irq;
            end

            if (b_ready) begin
                r_b_valid <= a_fire;
                if (a_fire) begin
                    r_b_lookup <= n_b_lookup;
                    r_b_pixel  <= n_b_pixel;
                    r_b_last   <= a_last;
                    r_b_irq    <= n_irq;
                    r_b_status <= n_b_status;
                    r_b_err    <= n_b_err;
                end
            end
        end
    end

    assign o_valid          = r_b_valid;
    assign o_out.pixel      = r_b_lookup ? pal_argb : r_b_pixel;
    assign o_out.last       = r_b_last;
    assign o_out.irq_level  = r_b_irq;
    assign o_out.status_bit = r_b_status;
    assign o_out.mode_error = r_b_err;

    a_no_rd_wr_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && rd_en))
        else $error("palette read and write in the same cycle");

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.mode_error |-> o_out.last && o_out.pixel == 32'd0)
        else $error("mode error result not a single zero pixel");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_a_valid)
        else $error("input stalled with empty expansion stage");

    a_status_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.status_bit |-> o_out.last && !r_b_lookup)
        else $error("status bit on a pixel result");

endmodule

FILE: sv/clut_palette.sv
// palette memory with one write and one registered read port
// per-entry written flags; unwritten entries read as zero including alpha
// depends on clut_pkg
module clut_palette #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [$clog2(PALETTE_DEPTH)-1:0] i_wr_addr,
    input  logic [23:0]                      i_wr_rgb,
    input  logic                             i_rd_en,
    input  logic [$clog2(PALETTE_DEPTH)-1:0] i_rd_addr,
    output logic [31:0]                      o_argb
);

    logic [23:0]              r_mem [PALETTE_DEPTH];
    logic [PALETTE_DEPTH-1:0] r_written;
    logic [23:0]              r_rd_rgb;
    logic                     r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_rgb;
        end
        if (i_rd_en) begin
            r_rd_rgb <= r_mem[i_rd_addr];
            r_rd_hit <= r_written[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_wr_en) begin
            r_written[i_wr_addr] <= 1'b1;
        end
    end

    assign o_argb = r_rd_hit ? {clut_pkg::ALPHA_OPAQUE, r_rd_rgb} : 32'd0;

endmodule

FILE: sim/pixel_check_pkg.sv
// prediction and scoreboard for the colour lookup pixel expander
// keeps its own palette, dac and interrupt state and checks each result transaction
// depends on clut_pkg
package pixel_check_pkg;

    import clut_pkg::*;

    localparam logic [2:0] MODE_UNDEF_LO = 3'd5;
    localparam logic [2:0] MODE_UNDEF_HI = 3'd6;
    localparam logic [2:0] REQ_RSVD_LO   = 3'd6;
    localparam logic [2:0] REQ_RSVD_HI   = 3'd7;

    localparam int REPORT_LIMIT = 10;

    class pixel_predictor;

        logic [2:0]  mode;
        logic        irq_off;
        logic [23:0] colour [256];
        bit          written [256];
        logic [7:0]  dac_addr;
        logic [1:0]  byte_cnt;
        logic [7:0]  partial [2];
        logic        toggle;
        logic        irq;

        t_out        expected_pixels [$];
        int unsigned mismatches;

        function new();
            mode     = 3'd0;
            irq_off  = 1'b1;
            dac_addr = 8'd0;
            byte_cnt = 2'd0;
            partial[0] = 8'd0;
            partial[1] = 8'd0;
            toggle   = 1'b0;
            irq      = 1'b0;
            mismatches = 0;
            for (int i = 0; i < 256; i++) begin
                colour[i]  = 24'd0;
                written[i] = 1'b0;
            end
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_COLOR_MODE)
                mode = val;
            else
                irq_off = val[0];
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void note_request(t_in req);
            logic [7:0] dac_byte;
            logic [7:0] src;
            logic [7:0] idx;
            logic [7:0] mask;
            int         bpp;
            int         count;
            t_out       r;
            dac_byte = req.data[31:24];
            r = '0;
            r.last = 1'b1;
            if (req.req_type == REQ_PIXEL && mode <= 3'd3) begin
                bpp   = 1 << mode;
                count = 8 >> mode;
                mask  = 8'hff << (8 - bpp);
                src   = req.data[7:0];
                for (int k = 0; k < count; k++) begin
                    idx = (src << (k * bpp)) & mask;
                    r.pixel = written[idx] ? {ALPHA_OPAQUE, colour[idx]} : 32'h0;
                    r.last = (k == count - 1);
                    r.irq_level = irq;
                    expected_pixels.push_back(r);
                end
                return;
            end
            case (req.req_type)
                REQ_PIXEL: begin
                    if (mode == MODE_DIRECT || mode == MODE_DIRECT_ALT)
                        r.pixel = req.data;
                    else
                        r.mode_error = 1'b1;
                end
                REQ_DAC_ADDR: begin
                    dac_addr = dac_byte;
                    byte_cnt = 2'd0;
                end
                REQ_DAC_COLOR: begin
                    if (byte_cnt >= 2'd2) begin
                        colour[dac_addr]  = {partial[0], partial[1], dac_byte};
                        written[dac_addr] = 1'b1;
                        dac_addr = dac_addr + 8'd1;
                        byte_cnt = 2'd0;
                    end else begin
                        partial[byte_cnt[0]] = dac_byte;
                        byte_cnt = byte_cnt + 2'd1;
                    end
                end
                REQ_FRAME_TICK: begin
                    if (!irq_off)
                        irq = 1'b1;
                end
                REQ_IRQ_ACK: irq = 1'b0;
                REQ_STATUS: begin
                    toggle = ~toggle;
                    r.status_bit = toggle;
                end
                default: ;
            endcase
            r.irq_level = irq;
            expected_pixels.push_back(r);
        endfunction

        function void check_pixel(t_out got);
            t_out exp;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: pixel %h last %b irq %b status %b err %b",
                             got.pixel, got.last, got.irq_level, got.status_bit,
                             got.mode_error);
                return;
            end
            exp = expected_pixels.pop_front();
            if (got !== exp) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch: pixel %h/%h last %b/%b irq %b/%b status %b/%b err %b/%b",
                             exp.pixel, got.pixel, exp.last, got.last,
                             exp.irq_level, got.irq_level, exp.status_bit, got.status_bit,
                             exp.mode_error, got.mode_error);
            end
        endfunction

    endclass

endpackage

FILE: sim/testbench.sv
// top level testbench for clut_ramdac_pixel_expander
// directed and random request transactions with random gaps on the request side and random stalls on the result side
// depends on clut_pkg, pixel_check_pkg and the block itself
module testbench;

    import clut_pkg::*;
    import pixel_check_pkg::*;

    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 36;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 300000;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_in                   i_in = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_out                  o_out;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    pixel_predictor predictor = new();

    logic [2:0] cur_mode = 3'd0;
    bit         hold_request = 1'b0;
    int         sender_calm = 0;
    int         cycle_count = 0;

    clut_ramdac_pixel_expander dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench: errors");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            predictor.check_pixel(o_out);
    end

    // result side stall, with calm stretches and the occasional long hold
    initial begin
        int w;
        int calm;
        calm = 0;
        wait (i_rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (calm > 0) begin
                w = 0;
                calm--;
            end else begin
                w = $urandom_range(0, 4);
                if ($urandom_range(0, 19) == 0)
                    calm = 25;
            end
            if (w > 0) begin
                i_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    task automatic send_req(input logic [2:0] kind, input logic [31:0] d);
        int  gap;
        t_in item;
        item.req_type = kind;
        item.data = d;
        if (sender_calm > 0) begin
            gap = 0;
            sender_calm--;
        end else begin
            gap = $urandom_range(0, 4);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in <= item;
        do @(posedge i_clk); while (o_stall);
        predictor.note_request(item);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (predictor.pending() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic program_registers(input logic [2:0] mode, input logic off);
        logic [CFG_DATA_W-1:0] off_word;
        off_word = {2'($urandom_range(0, 3)), off};
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_COLOR_MODE;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_idx <= CFG_IRQ_DISABLE;
        i_cfg_wdata <= off_word;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        predictor.set_register(CFG_COLOR_MODE, mode);
        predictor.set_register(CFG_IRQ_DISABLE, off_word);
        cur_mode = mode;
    endtask

    task automatic directed_traffic();
        send_req(REQ_PIXEL, 32'hffffff00);
        send_req(REQ_STATUS, 32'hffffffff);
        send_req(REQ_STATUS, 32'h0);
        send_req(REQ_FRAME_TICK, 32'h0);
        // entry 255 then wrap to entry 0
        send_req(REQ_DAC_ADDR, 32'hffffffff);
        send_req(REQ_DAC_COLOR, 32'h12000000);
        send_req(REQ_DAC_COLOR, 32'h34ffffff);
        send_req(REQ_DAC_COLOR, 32'h56000000);
        send_req(REQ_DAC_COLOR, 32'haaffffff);
        send_req(REQ_DAC_COLOR, 32'hbb000000);
        send_req(REQ_DAC_COLOR, 32'hccffffff);
        // address rewritten mid-colour drops the partial bytes
        send_req(REQ_DAC_ADDR, 32'h80000000);
        send_req(REQ_DAC_COLOR, 32'h11000000);
        send_req(REQ_DAC_ADDR, 32'h80000000);
        send_req(REQ_DAC_COLOR, 32'hde000000);
        send_req(REQ_DAC_COLOR, 32'had000000);
        send_req(REQ_DAC_COLOR, 32'hbe000000);
        send_req(REQ_PIXEL, 32'h000000aa);
        send_req(REQ_PIXEL, 32'h000000ff);
        send_req(REQ_RSVD_LO, 32'hffffffff);
        send_req(REQ_RSVD_HI, 32'h0);
        send_req(REQ_IRQ_ACK, 32'h0);
        wait_drained();
        program_registers({1'b0, MODE_1BPP}, 1'b0);
        send_req(REQ_FRAME_TICK, 32'h0);
        send_req(REQ_PIXEL, 32'h00000080);
        wait_drained();
        // disabling leaves the pending interrupt in place
        program_registers({1'b0, MODE_8BPP}, 1'b1);
        send_req(REQ_PIXEL, 32'h000000ff);
        send_req(REQ_IRQ_ACK, 32'h0);
        wait_drained();
        program_registers(MODE_DIRECT_ALT, 1'b1);
        send_req(REQ_PIXEL, 32'hffffffff);
        wait_drained();
        program_registers(MODE_UNDEF_LO, 1'b1);
        send_req(REQ_PIXEL, 32'hffffffff);
        wait_drained();
    endtask

    task automatic random_traffic(input int n);
        int          sent;
        int          r;
        int          writes;
        logic [7:0]  base;
        logic [7:0]  align;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 39) == 0)
                sender_calm = 30;
            if (r < 45) begin
                send_req(REQ_PIXEL, $urandom);
                sent++;
            end else if (r < 70) begin
                align = (cur_mode <= 3'd3) ? 8'(8'hff << (8 - (1 << cur_mode))) : 8'hff;
                base = 8'($urandom);
                if ($urandom_range(0, 1) == 1)
                    base = base & align;
                writes = 3 * $urandom_range(1, 3);
                // broken colour sequence now and then
                if ($urandom_range(0, 4) == 0)
                    writes = writes - $urandom_range(1, 2);
                send_req(REQ_DAC_ADDR, {base, 24'($urandom)});
                for (int i = 0; i < writes; i++)
                    send_req(REQ_DAC_COLOR, $urandom);
                sent = sent + 1 + writes;
            end else if (r < 76) begin
                send_req(REQ_FRAME_TICK, $urandom);
                sent++;
            end else if (r < 82) begin
                send_req(REQ_IRQ_ACK, $urandom);
                sent++;
            end else if (r < 90) begin
                send_req(REQ_STATUS, $urandom);
                sent++;
            end else if (r < 94) begin
                send_req(REQ_DAC_COLOR, $urandom);
                sent++;
            end else if (r < 97) begin
                send_req(REQ_DAC_ADDR, $urandom);
                sent++;
            end else begin
                send_req($urandom_range(0, 1) ? REQ_RSVD_HI : REQ_RSVD_LO, $urandom);
                sent++;
            end
            if ($urandom_range(0, 59) == 0)
                wait_drained();
        end
    endtask

    function automatic logic [2:0] phase_mode(input int p);
        case (p)
            0:       return {1'b0, MODE_1BPP};
            1:       return {1'b0, MODE_2BPP};
            2:       return {1'b0, MODE_4BPP};
            3:       return {1'b0, MODE_8BPP};
            4:       return MODE_DIRECT;
            5:       return MODE_DIRECT_ALT;
            6:       return MODE_UNDEF_LO;
            7:       return MODE_UNDEF_HI;
            8:       return {1'b0, MODE_8BPP};
            9:       return {1'b0, MODE_4BPP};
            10:      return {1'b0, MODE_2BPP};
            default: return {1'b0, MODE_1BPP};
        endcase
    endfunction

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_traffic();
        for (int p = 0; p < PHASES; p++) begin
            program_registers(phase_mode(p), p[0]);
            if (p == 0 || p == 3)
                hold_request = 1'b1;
            random_traffic(PHASE_ITEMS);
            wait_drained();
        end
        repeat (10) @(posedge i_clk);
        if (predictor.mismatches == 0 && predictor.pending() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
